FILE: rtl/pfla_pkg.sv
// Shared widths, codes, state and control/status types for the page free list allocator.
package pfla_pkg;

   localparam int ADDR_W      = 40;
   localparam int OP_W        = 2;
   localparam int STATUS_W    = 2;
   localparam int COUNT_W     = 16;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 40;

   localparam int DEFAULT_MAX_PAGES  = 32768;
   localparam int DEFAULT_PAGE_BYTES = 4096;

   localparam logic [ADDR_W-1:0] RESET_REGION_START = 40'h00_8000_0000;
   localparam logic [ADDR_W-1:0] RESET_REGION_LIMIT = 40'h00_8800_0000;

   localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
   localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_REGION_START = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REGION_LIMIT = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_BAD   = 2'd2,
      STATUS_FULL  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_POP
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load_init;
      logic       push_free;
      logic       push_load;
      logic       pop;
      logic       rsp_write;
      logic       rsp_use_rdata;
      status_type rsp_status;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic fill_empty;
      logic fill_full;
      logic free_ok;
      logic load_more;
   } dp_status_type;

endpackage

FILE: rtl/pfla_req_if.sv
// Request channel: valid/ready handshake carrying opcode and page address.
interface pfla_req_if import pfla_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   opcode;
   logic [ADDR_W-1:0] page_address;

   modport source (output valid, output opcode, output page_address, input ready);
   modport sink   (input valid, input opcode, input page_address, output ready);
endinterface

FILE: rtl/pfla_rsp_if.sv
// Response channel: valid/ready handshake carrying granted address, status and free count.
interface pfla_rsp_if import pfla_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ADDR_W-1:0]   granted_address;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  free_count;

   modport source (output valid, output granted_address, output status,
                   output free_count, input ready);
   modport sink   (input valid, input granted_address, input status,
                   input free_count, output ready);
endinterface

FILE: rtl/pfla_ctrl.sv
// Controller state machine: request acceptance, load walk sequencing and response valid.
module pfla_ctrl import pfla_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [OP_W-1:0] req_opcode,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type dp_status,
   output cmd_type       cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign accept = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_opcode == OP_LOAD) begin
                  state_in = ST_LOAD;
               end else if (req_opcode == OP_ALLOC && !dp_status.fill_empty) begin
                  state_in = ST_POP;
               end
            end
         end
         ST_LOAD: begin
            if (!dp_status.load_more || dp_status.fill_full) begin
               state_in = ST_IDLE;
            end
         end
         ST_POP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      cmd.rsp_status = STATUS_OK;
      case (state_ff)
         ST_IDLE: begin
            // The output word must be empty or leaving before a new item comes in.
            req_ready = !reset && (!rsp_valid_ff || rsp_ready);
            if (accept) begin
               case (req_opcode)
                  OP_LOAD: begin
                     cmd.load_init = 1'b1;
                  end
                  OP_ALLOC: begin
                     if (dp_status.fill_empty) begin
                        cmd.rsp_write  = 1'b1;
                        cmd.rsp_status = STATUS_EMPTY;
                     end else begin
                        cmd.pop = 1'b1;
                     end
                  end
                  OP_FREE: begin
                     cmd.rsp_write = 1'b1;
                     if (!dp_status.free_ok) begin
                        cmd.rsp_status = STATUS_BAD;
                     end else if (dp_status.fill_full) begin
                        cmd.rsp_status = STATUS_FULL;
                     end else begin
                        cmd.push_free = 1'b1;
                     end
                  end
                  default: begin
                     cmd.rsp_write = 1'b1;
                  end
               endcase
            end
         end
         ST_LOAD: begin
            if (!dp_status.load_more) begin
               cmd.rsp_write = 1'b1;
            end else if (dp_status.fill_full) begin
               cmd.rsp_write  = 1'b1;
               cmd.rsp_status = STATUS_FULL;
            end else begin
               cmd.push_load = 1'b1;
            end
         end
         ST_POP: begin
            cmd.rsp_write     = 1'b1;
            cmd.rsp_use_rdata = 1'b1;
         end
         default: begin
            cmd = '0;
            cmd.rsp_status = STATUS_OK;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_write) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_pop_then_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_POP |=> rsp_valid_ff)
      else $error("pop did not produce a response word");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_write |-> (!rsp_valid_ff || rsp_ready))
      else $error("response word overwritten before it was taken");

   a_alloc_to_pop: assert property (@(posedge clock) disable iff (reset)
      (accept && req_opcode == OP_ALLOC && !dp_status.fill_empty) |=> state_ff == ST_POP)
      else $error("alloc from a non-empty stack did not enter the pop state");
`endif

endmodule

FILE: rtl/pfla_dpath.sv
// Datapath: region registers, frame stack memory, fill count, load cursor and response word.
module pfla_dpath import pfla_pkg::*; #(
   parameter int MAX_PAGES  = DEFAULT_MAX_PAGES,
   parameter int PAGE_BYTES = DEFAULT_PAGE_BYTES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   input  logic [ADDR_W-1:0]      req_page_address,
   input  cmd_type                cmd,
   output dp_status_type          dp_status,
   output logic [ADDR_W-1:0]      rsp_granted_address,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [COUNT_W-1:0]     rsp_free_count
);

   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int FRAME_W    = ADDR_W - PAGE_SHIFT;
   localparam int FILL_W     = $clog2(MAX_PAGES + 1);
   localparam int IDX_W      = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;

   logic [ADDR_W-1:0]   start_ff, limit_ff;
   logic [FILL_W-1:0]   fill_ff, fill_in, fill_dec;
   logic [FRAME_W:0]    cur_ff, cur_in, first_frame;
   logic [FRAME_W-1:0]  limit_frame, push_frame, rd_data_ff;
   logic                push;
   logic [FRAME_W-1:0]  frame_mem [MAX_PAGES];
   logic [ADDR_W-1:0]   grant_ff;
   status_type          status_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic [FILL_W+COUNT_W-1:0] count_wide;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= RESET_REGION_START;
         limit_ff <= RESET_REGION_LIMIT;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_REGION_START: start_ff <= csr_write_data[ADDR_W-1:0];
            CSR_REGION_LIMIT: limit_ff <= csr_write_data[ADDR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Page p of the region fits when its frame number is below floor(limit / page size).
   assign limit_frame = limit_ff[ADDR_W-1:PAGE_SHIFT];
   assign first_frame = {1'b0, start_ff[ADDR_W-1:PAGE_SHIFT]}
                        + (FRAME_W+1)'(|start_ff[PAGE_SHIFT-1:0]);

   assign fill_dec = fill_ff - FILL_W'(1);
   assign push     = cmd.push_free || cmd.push_load;

   assign dp_status.fill_empty = (fill_ff == '0);
   assign dp_status.fill_full  = (fill_ff == FILL_W'(MAX_PAGES));
   assign dp_status.free_ok    = (req_page_address[PAGE_SHIFT-1:0] == '0)
                                 && (req_page_address >= start_ff)
                                 && (req_page_address < limit_ff);
   assign dp_status.load_more  = (cur_ff < {1'b0, limit_frame});

   assign push_frame = cmd.push_free ? req_page_address[ADDR_W-1:PAGE_SHIFT]
                                     : cur_ff[FRAME_W-1:0];

   always_comb begin
      fill_in = fill_ff;
      if (push) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (cmd.pop) begin
         fill_in = fill_dec;
      end
   end

   always_comb begin
      cur_in = cur_ff;
      if (cmd.load_init) begin
         cur_in = first_frame;
      end else if (cmd.push_load) begin
         cur_in = cur_ff + (FRAME_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         frame_mem[fill_ff[IDX_W-1:0]] <= push_frame;
      end
      rd_data_ff <= frame_mem[fill_dec[IDX_W-1:0]];
   end

   assign count_wide = {{COUNT_W{1'b0}}, fill_in};

   always_ff @(posedge clock) begin
      if (cmd.rsp_write) begin
         grant_ff  <= cmd.rsp_use_rdata ? {rd_data_ff, {PAGE_SHIFT{1'b0}}} : '0;
         status_ff <= cmd.rsp_status;
         count_ff  <= count_wide[COUNT_W-1:0];
      end
   end

   assign rsp_granted_address = grant_ff;
   assign rsp_status          = status_ff;
   assign rsp_free_count      = count_ff;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(MAX_PAGES))
      else $error("stack fill exceeds capacity");

   a_push_pop_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.pop && push))
      else $error("push and pop in the same cycle");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      push |=> fill_ff == $past(fill_ff) + FILL_W'(1))
      else $error("push did not advance the fill count");
`endif

endmodule

FILE: rtl/page_free_list_allocator.sv
// Top level of the LIFO physical page allocator: controller plus datapath.
// Usage:
//   req_chan carries one word per operation: opcode 0 loads every whole page of
//   [region_start rounded up, region_limit) onto the stack until it is full, 1
//   allocates the top page, 2 frees page_address. rsp_chan returns exactly one
//   word per request with granted_address, status (ok, empty, bad address, full)
//   and free_count. The csr_ port writes region_start (index 0) and region_limit
//   (index 1); write them only while no request is in flight.
// Timing:
//   Free, unused opcodes and alloc from an empty stack answer in the cycle after
//   acceptance. A successful alloc answers through the pop state, after the
//   registered read of the frame stack memory. The load walk pushes one page per
//   cycle until the region ends or the stack is full, then answers.
//   One request is handled at a time; the next one is taken as soon as the
//   block is idle and the response register is empty or being read that cycle.
// Reset:
//   Synchronous reset empties the stack (fill count zero) and restores the
//   region registers to 0x8000_0000 and 0x8800_0000; the stack memory itself
//   is not cleared. A stalled response holds its word and blocks new requests.
module page_free_list_allocator import pfla_pkg::*; #(
   parameter int MAX_PAGES  = DEFAULT_MAX_PAGES,
   parameter int PAGE_BYTES = DEFAULT_PAGE_BYTES
) (
   input  logic                   clock,
   input  logic                   reset,
   pfla_req_if.sink               req_chan,
   pfla_rsp_if.source             rsp_chan,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   cmd_type       cmd;
   dp_status_type dp_status;

   pfla_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_ready  (req_chan.ready),
      .req_opcode (req_chan.opcode),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .dp_status  (dp_status),
      .cmd        (cmd)
   );

   pfla_dpath #(
      .MAX_PAGES  (MAX_PAGES),
      .PAGE_BYTES (PAGE_BYTES)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .req_page_address    (req_chan.page_address),
      .cmd                 (cmd),
      .dp_status           (dp_status),
      .rsp_granted_address (rsp_chan.granted_address),
      .rsp_status          (rsp_chan.status),
      .rsp_free_count      (rsp_chan.free_count)
   );

endmodule
